### src/crpm_pkg.sv
// Shared types, constants and helper functions for the cell ring projection mixer.
`timescale 1ns / 1ps
`default_nettype none
package crpm_pkg;

  localparam int CELLS_DEF = 64;
  localparam int CHANNELS  = 4;
  localparam int VSTEP     = 9;

  localparam logic [63:0] K_CH    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] K_CELL  = 64'h517cc1b727220a95;
  localparam logic [63:0] K_FMIX1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] K_FMIX2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_XOR   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_XOR    = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RD_C = 2'd0,
    RD_L = 2'd1,
    RD_R = 2'd2,
    RD_V = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    M_HOLD         = 3'd0,
    M_LOAD_C       = 3'd1,
    M_XOR_ROTL_L   = 3'd2,
    M_XOR_ROTR_R   = 3'd3,
    M_XOR_ROTL_V   = 3'd4,
    M_XOR_PROD     = 3'd5,
    M_XOR_PROD_SH  = 3'd6,
    M_LOAD_PROD_SH = 3'd7
  } m_op_t;

  typedef enum logic [1:0] {
    MUL_CH   = 2'd0,
    MUL_CELL = 2'd1,
    MUL_K1   = 2'd2,
    MUL_K2   = 2'd3
  } mul_sel_t;

  // Partial products of a 64x64 multiply kept modulo 2^64.
  typedef enum logic [1:0] {
    PH_LO = 2'd0,
    PH_MA = 2'd1,
    PH_MB = 2'd2
  } mul_ph_t;

  typedef struct packed {
    logic     capture;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    logic     wr_xor;
    m_op_t    m_op;
    logic     mul_en;
    mul_sel_t mul_sel;
    mul_ph_t  mul_ph;
    logic     emit;
    logic     emit_ok;
    logic     emit_proj;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
  } dp_stat_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] s);
    logic [127:0] t;
    t = {v, v} << s;
    return t[127:64];
  endfunction

  function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] s);
    logic [127:0] t;
    t = {v, v} >> s;
    return t[63:0];
  endfunction

  function automatic logic [31:0] fold32(input logic [63:0] x);
    return x[31:0] ^ x[63:32];
  endfunction

endpackage
`default_nettype wire

### src/crpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module crpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/crpm_ctrl.sv
// Controller state machine that sequences loads, xors, projection queries and rejects.
`timescale 1ns / 1ps
`default_nettype none
module crpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  crpm_pkg::dp_stat_t stat,
  output crpm_pkg::dp_cmd_t  cmd
);
  import crpm_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_WRITE  = 13'b0000000000010,
    S_XREAD  = 13'b0000000000100,
    S_XWRITE = 13'b0000000001000,
    S_RD_C   = 13'b0000000010000,
    S_RD_L   = 13'b0000000100000,
    S_RD_R   = 13'b0000001000000,
    S_RD_V   = 13'b0000010000000,
    S_MIX_V  = 13'b0000100000000,
    S_MUL    = 13'b0001000000000,
    S_APPLY  = 13'b0010000000000,
    S_EMIT   = 13'b0100000000000,
    S_REJECT = 13'b1000000000000
  } state_t;

  state_t   state_r, state_nxt;
  mul_sel_t job_r, job_nxt;
  mul_ph_t  ph_r, ph_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (stat.kind)
            KIND_LOAD:  state_nxt = S_WRITE;
            KIND_XOR:   state_nxt = S_XREAD;
            KIND_QUERY: state_nxt = S_RD_C;
            default:    state_nxt = S_REJECT;
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.emit    = 1'b1;
        cmd.emit_ok = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_XREAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_C;
        state_nxt  = S_XWRITE;
      end
      S_XWRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_xor  = 1'b1;
        cmd.emit    = 1'b1;
        cmd.emit_ok = 1'b1;
        state_nxt   = S_IDLE;
      end
      // Each read's registered data is mixed in by the state that follows the read.
      S_RD_C: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_C;
        state_nxt  = S_RD_L;
      end
      S_RD_L: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_L;
        cmd.m_op   = M_LOAD_C;
        state_nxt  = S_RD_R;
      end
      S_RD_R: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_R;
        cmd.m_op   = M_XOR_ROTL_L;
        state_nxt  = S_RD_V;
      end
      S_RD_V: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_V;
        cmd.m_op   = M_XOR_ROTR_R;
        state_nxt  = S_MIX_V;
      end
      S_MIX_V: begin
        cmd.m_op  = M_XOR_ROTL_V;
        job_nxt   = MUL_CH;
        ph_nxt    = PH_LO;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = job_r;
        cmd.mul_ph  = ph_r;
        case (ph_r)
          PH_LO:   ph_nxt = PH_MA;
          PH_MA:   ph_nxt = PH_MB;
          default: state_nxt = S_APPLY;
        endcase
      end
      S_APPLY: begin
        ph_nxt = PH_LO;
        case (job_r)
          MUL_CH: begin
            cmd.m_op  = M_XOR_PROD;
            job_nxt   = MUL_CELL;
            state_nxt = S_MUL;
          end
          MUL_CELL: begin
            cmd.m_op  = M_XOR_PROD_SH;
            job_nxt   = MUL_K1;
            state_nxt = S_MUL;
          end
          MUL_K1: begin
            cmd.m_op  = M_LOAD_PROD_SH;
            job_nxt   = MUL_K2;
            state_nxt = S_MUL;
          end
          default: begin
            cmd.m_op  = M_LOAD_PROD_SH;
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_ok   = 1'b1;
        cmd.emit_proj = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_REJECT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= MUL_CH;
      ph_r    <= PH_LO;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      ph_r    <= ph_nxt;
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == S_IDLE) |=> (state_r != S_IDLE))
    else $error("accepted item did not leave idle");

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE))
    else $error("controller not idle after emitting a result");

  a_mul_done_applies: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && ph_r == PH_MB) |=> (state_r == S_APPLY))
    else $error("multiply did not finish after its last partial product");
`endif

endmodule
`default_nettype wire

### src/crpm_dp.sv
// Datapath: cell store, neighbor addressing, mixing register, shared multiplier, result register.
`timescale 1ns / 1ps
`default_nettype none
module crpm_dp #(
  parameter int CELLS = crpm_pkg::CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  crpm_pkg::dp_cmd_t  cmd,
  output crpm_pkg::dp_stat_t stat,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_cell_index,
  input  logic [63:0]        in_operand_value,
  input  logic [5:0]         in_channel,
  output logic               out_valid,
  output logic [31:0]        out_projection_out,
  output logic               out_ok
);
  import crpm_pkg::*;

  localparam int AW = $clog2(CELLS);
  localparam logic [AW:0]   NCELL = (AW+1)'(CELLS);
  localparam logic [AW:0]   VST   = (AW+1)'(VSTEP);
  localparam logic [AW-1:0] LAST  = AW'(CELLS - 1);
  localparam logic [8:0]    NCELL9 = 9'(CELLS);
  localparam logic [6:0]    NCHAN  = 7'(CHANNELS);

  logic [AW-1:0]    cell_r;
  logic [63:0]      op_r;
  logic [5:0]       ch_r;
  logic [63:0]      m_r, m_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [CELLS-1:0] valid_r;
  logic             rvld_r;
  logic             out_valid_r;
  logic [31:0]      out_proj_r;
  logic             out_ok_r;

  logic             cell_ok, chan_ok;
  logic [AW-1:0]    left_a, right_a, vert_a, rd_addr;
  logic [AW:0]      vsum;
  logic [63:0]      ram_rdata, rd_eff, wr_data;
  logic [5:0]       sh_l, sh_r, sh_v;
  logic [63:0]      mul_a, mul_b, prod, t_xor;
  logic [31:0]      ma, mb;

  // Item decode for the controller.
  assign cell_ok = ({1'b0, in_cell_index} < NCELL9);
  assign chan_ok = ({1'b0, in_channel} < NCHAN);

  always_comb begin
    case (in_action)
      ACT_LOAD:  stat.kind = cell_ok ? KIND_LOAD : KIND_REJECT;
      ACT_XOR:   stat.kind = (cell_ok && in_operand_value != 64'd0) ? KIND_XOR : KIND_REJECT;
      ACT_QUERY: stat.kind = (cell_ok && chan_ok) ? KIND_QUERY : KIND_REJECT;
      default:   stat.kind = KIND_REJECT;
    endcase
  end

  // Ring neighbors; one subtraction wraps the plus-nine step while CELLS is at least nine.
  assign left_a  = (cell_r == '0) ? LAST : cell_r - AW'(1);
  assign right_a = (cell_r == LAST) ? '0 : cell_r + AW'(1);
  assign vsum    = {1'b0, cell_r} + VST;
  assign vert_a  = (vsum >= NCELL) ? AW'(vsum - NCELL) : vsum[AW-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RD_C:    rd_addr = cell_r;
      RD_L:    rd_addr = left_a;
      RD_R:    rd_addr = right_a;
      default: rd_addr = vert_a;
    endcase
  end

  crpm_ram #(
    .WIDTH(64),
    .DEPTH(CELLS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cell_r),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // A cell never written since reset reads as zero.
  assign rd_eff  = rvld_r ? ram_rdata : 64'd0;
  assign wr_data = cmd.wr_xor ? (rd_eff ^ op_r) : op_r;

  assign sh_l = ch_r + 6'd1;
  assign sh_r = ch_r + ch_r + ch_r + 6'd5;
  assign sh_v = (ch_r << 2) + ch_r + 6'd7;

  // One 32x32 multiplier builds the low 64 bits of a product in three steps.
  always_comb begin
    case (cmd.mul_sel)
      MUL_CH: begin
        mul_a = 64'(7'({1'b0, ch_r} + 7'd1));
        mul_b = K_CH;
      end
      MUL_CELL: begin
        mul_a = 64'(9'(cell_r) + 9'd1);
        mul_b = K_CELL;
      end
      MUL_K1: begin
        mul_a = m_r;
        mul_b = K_FMIX1;
      end
      default: begin
        mul_a = m_r;
        mul_b = K_FMIX2;
      end
    endcase
  end

  always_comb begin
    case (cmd.mul_ph)
      PH_LO: begin
        ma = mul_a[31:0];
        mb = mul_b[31:0];
      end
      PH_MA: begin
        ma = mul_a[63:32];
        mb = mul_b[31:0];
      end
      default: begin
        ma = mul_a[31:0];
        mb = mul_b[63:32];
      end
    endcase
  end

  assign prod = 64'(ma) * 64'(mb);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.mul_en) begin
      if (cmd.mul_ph == PH_LO) begin
        acc_nxt = prod;
      end else begin
        acc_nxt = acc_r + {prod[31:0], 32'd0};
      end
    end
  end

  assign t_xor = m_r ^ acc_r;

  always_comb begin
    case (cmd.m_op)
      M_HOLD:         m_nxt = m_r;
      M_LOAD_C:       m_nxt = rd_eff;
      M_XOR_ROTL_L:   m_nxt = m_r ^ rotl64(rd_eff, sh_l);
      M_XOR_ROTR_R:   m_nxt = m_r ^ rotr64(rd_eff, sh_r);
      M_XOR_ROTL_V:   m_nxt = m_r ^ rotl64(rd_eff, sh_v);
      M_XOR_PROD:     m_nxt = t_xor;
      M_XOR_PROD_SH:  m_nxt = t_xor ^ (t_xor >> 33);
      M_LOAD_PROD_SH: m_nxt = acc_r ^ (acc_r >> 33);
      default:        m_nxt = m_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.wr_en) begin
        valid_r[cell_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cell_r <= in_cell_index[AW-1:0];
      op_r   <= in_operand_value;
      ch_r   <= in_channel;
    end
    if (cmd.rd_en) begin
      rvld_r <= valid_r[rd_addr];
    end
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    if (cmd.emit) begin
      out_ok_r   <= cmd.emit_ok;
      out_proj_r <= cmd.emit_proj ? fold32(m_r) : 32'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_projection_out = out_proj_r;
  assign out_ok             = out_ok_r;

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_proj_r == 32'd0))
    else $error("rejected item carries a nonzero projection");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> ({1'b0, cell_r} < NCELL))
    else $error("cell write outside the ring");
`endif

endmodule
`default_nettype wire

### src/cell_ring_projection_mixer_top.sv
// Top level of the cell ring projection mixer: controller plus datapath.
// A load writes its cell and emits; an xor reads its cell, then writes it and emits; a reject emits;
// a projection query does four cell reads, then four 64-bit multiplies
// on the single shared 32x32 multiplier, then emits. Each result is registered onto out_valid.
// One item is taken at a time: start is accepted only while idle; busy is high until the result appears.
// Reset (synchronous, rst_n low) clears the controller, the result strobe and all cell valid bits,
// so every cell reads as zero at once; no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module cell_ring_projection_mixer_top #(
  parameter int CELLS = crpm_pkg::CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_cell_index,
  input  logic [63:0] in_operand_value,
  input  logic [5:0]  in_channel,
  output logic        out_valid,
  output logic [31:0] out_projection_out,
  output logic        out_ok
);
  import crpm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  crpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  crpm_dp #(
    .CELLS(CELLS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_cell_index      (in_cell_index),
    .in_operand_value   (in_operand_value),
    .in_channel         (in_channel),
    .out_valid          (out_valid),
    .out_projection_out (out_projection_out),
    .out_ok             (out_ok)
  );

endmodule
`default_nettype wire
